// ===== hw/rtl/vm_pkg.sv =====
package vm_pkg;

  // Component width in use; inputs arrive on full-width ports and only the
  // low COMPONENT_WIDTH bits take part (the top one is the sign).
  localparam int COMPONENT_WIDTH = 32;
  localparam int IN_W            = 32;
  localparam int MAG_W           = 31;
  localparam int RAD_W           = 2 * COMPONENT_WIDTH;
  localparam int ROOT_W          = COMPONENT_WIDTH;

  // Two digit steps per root stage.
  localparam int STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES     = (ROOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam logic [MAG_W-1:0] MAG_LIMIT =
    MAG_W'((64'd1 << (COMPONENT_WIDTH - 1)) - 64'd1);

  typedef logic [COMPONENT_WIDTH-1:0] comp_t;
  typedef logic [RAD_W-1:0]           rad_t;
  typedef logic [ROOT_W-1:0]          root_t;

  typedef struct packed {
    rad_t rem;
    rad_t acc;
  } sqrt_state_t;

  // Absolute value of a two's complement component, as unsigned.
  function automatic comp_t comp_abs(input comp_t raw);
    comp_t neg;
    neg = comp_t'(~raw + comp_t'(1));
    return raw[COMPONENT_WIDTH-1] ? neg : raw;
  endfunction

  // One restoring digit step; step 0 uses the highest digit weight.
  function automatic sqrt_state_t sqrt_digit(input sqrt_state_t cur, input int step);
    rad_t              wt;
    logic [RAD_W:0]    trial;
    sqrt_state_t       nxt;
    wt    = rad_t'(1) << (2 * (ROOT_W - 1 - step));
    trial = {1'b0, cur.acc} + {1'b0, wt};
    if ({1'b0, cur.rem} >= trial) begin
      nxt.rem = cur.rem - trial[RAD_W-1:0];
      nxt.acc = (cur.acc >> 1) + wt;
    end else begin
      nxt.rem = cur.rem;
      nxt.acc = cur.acc >> 1;
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/vec3_magnitude.sv =====
// Euclidean length of a three-component signed fixed-point vector.
// Input channel: valid_i with x/y/z_component_i; a transaction is taken at a
// rising edge with valid_i high and stall_o low. Output channel: valid_o with
// magnitude_o and saturated_o; a transaction completes when stall_i is low.
// magnitude_o is floor(sqrt(x^2 + y^2 + z^2)) in the input's fixed-point
// scaling, clamped to the signed maximum with saturated_o raised when clamped.
// Throughput: one transaction per cycle while stall_o is low. The result passes
// through abs, square and two adds, sixteen root stages of two digit steps
// each, and one output register before it shows on valid_o.
// Reset clears every valid bit, those of the output buffer too; data registers keep
// whatever they held. A stall on the output lets one further result drain
// into a skid slot; once that slot is full stall_o rises and the whole
// pipeline holds, so nothing is dropped or repeated.
module vec3_magnitude (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic signed [vm_pkg::IN_W-1:0]  x_component_i,
  input  logic signed [vm_pkg::IN_W-1:0]  y_component_i,
  input  logic signed [vm_pkg::IN_W-1:0]  z_component_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic [vm_pkg::MAG_W-1:0]        magnitude_o,
  output logic                            saturated_o
);

  logic                     en;
  logic                     skid_full;
  logic                     rad_valid;
  vm_pkg::rad_t             rad;
  logic                     root_valid;
  vm_pkg::root_t            root;
  logic                     sat;
  logic [vm_pkg::MAG_W-1:0] mag;

  // Advance the whole pipeline unless the skid slot is occupied.
  assign en      = !skid_full;
  assign stall_o = skid_full;

  vm_square u_square (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (valid_i),
    .x_component_i (x_component_i),
    .y_component_i (y_component_i),
    .z_component_i (z_component_i),
    .valid_o       (rad_valid),
    .rad_o         (rad)
  );

  vm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rad_valid),
    .rad_i   (rad),
    .valid_o (root_valid),
    .root_o  (root)
  );

  // The root fits the signed range exactly when its top bit is clear.
  assign sat = root[vm_pkg::ROOT_W-1];
  assign mag = sat ? vm_pkg::MAG_LIMIT
                   : vm_pkg::MAG_W'(root[vm_pkg::ROOT_W-2:0]);

  vm_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (root_valid && en),
    .magnitude_i (mag),
    .saturated_i (sat),
    .stall_i     (stall_i),
    .valid_o     (valid_o),
    .magnitude_o (magnitude_o),
    .saturated_o (saturated_o),
    .full_o      (skid_full)
  );

endmodule

// ===== hw/rtl/vm_square.sv =====
module vm_square (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [vm_pkg::IN_W-1:0] x_component_i,
  input  logic signed [vm_pkg::IN_W-1:0] y_component_i,
  input  logic signed [vm_pkg::IN_W-1:0] z_component_i,
  output logic                       valid_o,
  output vm_pkg::rad_t               rad_o
);

  vm_pkg::comp_t abs_d [3];
  vm_pkg::comp_t abs_q [3];
  vm_pkg::rad_t  sq_d  [3];
  vm_pkg::rad_t  sq_q  [3];
  vm_pkg::rad_t  part_d, part_q;
  vm_pkg::rad_t  zsq_q;
  vm_pkg::rad_t  rad_d, rad_q;
  logic [3:0]    valid_q;

  // Stage 1: magnitudes of the components.
  always_comb begin
    abs_d[0] = vm_pkg::comp_abs(x_component_i[vm_pkg::COMPONENT_WIDTH-1:0]);
    abs_d[1] = vm_pkg::comp_abs(y_component_i[vm_pkg::COMPONENT_WIDTH-1:0]);
    abs_d[2] = vm_pkg::comp_abs(z_component_i[vm_pkg::COMPONENT_WIDTH-1:0]);
  end

  // Stage 2: one square per lane.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = vm_pkg::RAD_W'(abs_q[i]) * vm_pkg::RAD_W'(abs_q[i]);
    end
  end

  // Stages 3 and 4: one wide add each.
  assign part_d = sq_q[0] + sq_q[1];
  assign rad_d  = part_q + zsq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q  <= abs_d;
      sq_q   <= sq_d;
      part_q <= part_d;
      zsq_q  <= sq_q[2];
      rad_q  <= rad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  assign valid_o = valid_q[3];
  assign rad_o   = rad_q;

endmodule

// ===== hw/rtl/vm_sqrt.sv =====
module vm_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  vm_pkg::rad_t   rad_i,
  output logic           valid_o,
  output vm_pkg::root_t  root_o
);

  localparam int N = vm_pkg::SQRT_STAGES;

  vm_pkg::sqrt_state_t stage_in [N];
  vm_pkg::sqrt_state_t stage_d  [N];
  vm_pkg::sqrt_state_t stage_q  [N];
  logic [N-1:0]        valid_q;

  always_comb begin
    stage_in[0].rem = rad_i;
    stage_in[0].acc = '0;
    for (int s = 1; s < N; s++) begin
      stage_in[s] = stage_q[s-1];
    end
  end

  // Each stage retires up to two digits; the last one may carry fewer.
  always_comb begin
    for (int s = 0; s < N; s++) begin
      stage_d[s] = stage_in[s];
      for (int j = 0; j < vm_pkg::STEPS_PER_STAGE; j++) begin
        if (s * vm_pkg::STEPS_PER_STAGE + j < vm_pkg::ROOT_W) begin
          stage_d[s] = vm_pkg::sqrt_digit(stage_d[s], s * vm_pkg::STEPS_PER_STAGE + j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[N-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = stage_q[N-1].acc[vm_pkg::ROOT_W-1:0];

endmodule

// ===== hw/rtl/vm_outbuf.sv =====
module vm_outbuf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [vm_pkg::MAG_W-1:0] magnitude_i,
  input  logic                     saturated_i,
  input  logic                     stall_i,
  output logic                     valid_o,
  output logic [vm_pkg::MAG_W-1:0] magnitude_o,
  output logic                     saturated_o,
  output logic                     full_o
);

  logic                     out_valid_q, out_valid_d;
  logic [vm_pkg::MAG_W-1:0] out_mag_q, out_mag_d;
  logic                     out_sat_q, out_sat_d;
  logic                     skid_valid_q, skid_valid_d;
  logic [vm_pkg::MAG_W-1:0] skid_mag_q, skid_mag_d;
  logic                     skid_sat_q, skid_sat_d;
  logic                     take;

  assign take = out_valid_q && !stall_i;

  // Push only arrives while the skid slot is empty.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_mag_d    = out_mag_q;
    out_sat_d    = out_sat_q;
    skid_valid_d = skid_valid_q;
    skid_mag_d   = skid_mag_q;
    skid_sat_d   = skid_sat_q;
    if (skid_valid_q) begin
      if (take) begin
        out_mag_d    = skid_mag_q;
        out_sat_d    = skid_sat_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_mag_d   = magnitude_i;
        out_sat_d   = saturated_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_mag_d   = magnitude_i;
        skid_sat_d   = saturated_i;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mag_q  <= out_mag_d;
    out_sat_q  <= out_sat_d;
    skid_mag_q <= skid_mag_d;
    skid_sat_q <= skid_sat_d;
  end

  assign valid_o     = out_valid_q;
  assign magnitude_o = out_mag_q;
  assign saturated_o = out_sat_q;
  assign full_o      = skid_valid_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for vec3_magnitude.
// Drive vectors from a queue of pending transactions, predict each length on
// acceptance, and compare every completed output transaction against the
// oldest prediction.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1800;
  // Keep the last vectors of the run free of any idling on either side.
  localparam int CALM_TAIL = 150;

  // Components that put the root right at the saturation point: one axis
  // near full scale, two equal axes near 2^31/sqrt(2), three near 2^31/sqrt(3).
  localparam logic [vm_pkg::IN_W-1:0] EDGE_ONE   = 32'd2147483600;
  localparam logic [vm_pkg::IN_W-1:0] EDGE_TWO   = 32'd1518500250;
  localparam logic [vm_pkg::IN_W-1:0] EDGE_THREE = 32'd1239850262;

  typedef struct packed {
    logic [vm_pkg::IN_W-1:0] x;
    logic [vm_pkg::IN_W-1:0] y;
    logic [vm_pkg::IN_W-1:0] z;
  } vector_t;

  typedef struct packed {
    vector_t                  vec;
    logic [vm_pkg::MAG_W-1:0] magnitude;
    logic                     saturated;
  } length_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           valid_i;
  logic                           stall_o;
  logic signed [vm_pkg::IN_W-1:0] x_component_i;
  logic signed [vm_pkg::IN_W-1:0] y_component_i;
  logic signed [vm_pkg::IN_W-1:0] z_component_i;
  logic                           valid_o;
  logic                           stall_i;
  logic [vm_pkg::MAG_W-1:0]       magnitude_o;
  logic                           saturated_o;

  vector_t vectors_q[$];   // vectors still to be offered
  length_t lengths_q[$];   // predicted lengths awaiting their output transaction

  int  mismatches = 0;
  int  cycles     = 0;
  int  taken      = 0;
  bit  in_hs      = 1'b0;  // input transaction completed at the last rising edge
  bit  calm       = 1'b0;
  int  in_odds    = 0;     // 0: no input gaps, else one gap start in in_odds
  int  stall_odds = 0;
  int  in_gap     = 0;
  int  out_hold   = 0;
  int  odds_table[4] = '{0, 3, 8, 24};

  vec3_magnitude dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .x_component_i (x_component_i),
    .y_component_i (y_component_i),
    .z_component_i (z_component_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .magnitude_o   (magnitude_o),
    .saturated_o   (saturated_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Absolute value of a component, taken from its low COMPONENT_WIDTH bits.
  function automatic logic [63:0] axis_abs(input logic [vm_pkg::IN_W-1:0] raw);
    logic [63:0] v;
    v = 64'(raw[vm_pkg::COMPONENT_WIDTH-1:0]);
    if (raw[vm_pkg::COMPONENT_WIDTH-1]) begin
      v = (64'd1 << vm_pkg::COMPONENT_WIDTH) - v;
    end
    return v;
  endfunction

  // Predict the length: exact sum of squares, then build the floor root one
  // bit at a time from the top, keeping each bit whose square still fits.
  function automatic length_t euclid_length(input vector_t vec);
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] az;
    logic [63:0] radicand;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] ceiling;
    length_t     res;
    ax       = axis_abs(vec.x);
    ay       = axis_abs(vec.y);
    az       = axis_abs(vec.z);
    radicand = ax * ax + ay * ay + az * az;
    root     = 64'd0;
    for (int b = vm_pkg::COMPONENT_WIDTH; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial <= 64'hFFFF_FFFF && trial * trial <= radicand) begin
        root = trial;
      end
    end
    ceiling = (64'd1 << (vm_pkg::COMPONENT_WIDTH - 1)) - 64'd1;
    res.vec = vec;
    if (root > ceiling) begin
      res.magnitude = vm_pkg::MAG_W'(ceiling);
      res.saturated = 1'b1;
    end else begin
      res.magnitude = vm_pkg::MAG_W'(root);
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [vm_pkg::IN_W-1:0] random_sign(input logic [vm_pkg::IN_W-1:0] m);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [vm_pkg::IN_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return vm_pkg::IN_W'(1);
      2: return '1;
      3: return {1'b0, {(vm_pkg::IN_W-1){1'b1}}};
      4: return {1'b1, {(vm_pkg::IN_W-1){1'b0}}};
      default: return vm_pkg::IN_W'($urandom);
    endcase
  endfunction

  // Mix of full-range noise, small vectors, vectors at the saturation point,
  // single-axis vectors and corner values.
  function automatic vector_t random_vector();
    vector_t     v;
    int unsigned k;
    case ($urandom_range(0, 4))
      0: begin
        v.x = $urandom;
        v.y = $urandom;
        v.z = $urandom;
      end
      1: begin
        k   = $urandom_range(0, 20);
        v.x = random_sign($urandom & ((32'd1 << k) - 32'd1));
        v.y = random_sign($urandom & ((32'd1 << k) - 32'd1));
        v.z = random_sign($urandom & ((32'd1 << k) - 32'd1));
      end
      2: begin
        case ($urandom_range(0, 2))
          0: begin
            v.x = random_sign(EDGE_ONE + $urandom_range(0, 47));
            v.y = random_sign($urandom_range(0, 65535));
            v.z = random_sign($urandom_range(0, 255));
          end
          1: begin
            v.x = random_sign(EDGE_TWO + $urandom_range(0, 8) - 4);
            v.y = random_sign(EDGE_TWO + $urandom_range(0, 8) - 4);
            v.z = random_sign($urandom_range(0, 3));
          end
          default: begin
            v.x = random_sign(EDGE_THREE + $urandom_range(0, 8) - 4);
            v.y = random_sign(EDGE_THREE + $urandom_range(0, 8) - 4);
            v.z = random_sign(EDGE_THREE + $urandom_range(0, 8) - 4);
          end
        endcase
      end
      3: begin
        v   = '0;
        k   = $urandom_range(0, 2);
        if (k == 0) v.x = pick_extreme();
        else if (k == 1) v.y = pick_extreme();
        else v.z = pick_extreme();
      end
      default: begin
        v.x = pick_extreme();
        v.y = pick_extreme();
        v.z = pick_extreme();
      end
    endcase
    return v;
  endfunction

  task automatic queue_vector(input logic [vm_pkg::IN_W-1:0] x,
                              input logic [vm_pkg::IN_W-1:0] y,
                              input logic [vm_pkg::IN_W-1:0] z);
    vector_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vectors_q.push_back(v);
  endtask

  // Input driver: advance to the next vector only once the current transaction
  // has completed or nothing is on offer; hold the payload while stalled.
  always @(negedge clk_i) begin
    vector_t v;
    if (rst_ni && (!valid_i || in_hs)) begin
      if (in_gap == 0 && !calm && in_odds != 0 && $urandom_range(1, in_odds) == 1) begin
        in_gap = $urandom_range(1, 15);
      end
      if (in_gap > 0) begin
        in_gap--;
        valid_i <= 1'b0;
      end else if (vectors_q.size() != 0) begin
        v = vectors_q.pop_front();
        x_component_i <= v.x;
        y_component_i <= v.y;
        z_component_i <= v.z;
        valid_i       <= 1'b1;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // Output stall driver: random bursts of back-pressure, none in the tail.
  always @(negedge clk_i) begin
    if (out_hold == 0 && !calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_hold = $urandom_range(1, 15);
    end
    if (out_hold > 0) begin
      out_hold--;
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(input length_t want,
                                 input logic [vm_pkg::MAG_W-1:0] got_mag,
                                 input logic got_sat);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at cycle %0d: x=%h y=%h z=%h", cycles,
               want.vec.x, want.vec.y, want.vec.z);
      $display("  magnitude exp %0d got %0d, saturated exp %0b got %0b",
               want.magnitude, got_mag, want.saturated, got_sat);
    end
  endtask

  // Monitor: record accepted vectors with their predicted length, and check
  // each completed output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    vector_t v;
    length_t want;
    cycles <= cycles + 1;
    calm   <= vectors_q.size() < CALM_TAIL;
    in_hs  <= valid_i && !stall_o;
    if (valid_i && !stall_o) begin
      v.x = x_component_i;
      v.y = y_component_i;
      v.z = z_component_i;
      lengths_q.push_back(euclid_length(v));
      taken++;
      // Reshuffle how hard both sides idle every 64 accepted transactions.
      if (taken % 64 == 0) begin
        in_odds    <= odds_table[$urandom_range(0, 3)];
        stall_odds <= odds_table[$urandom_range(0, 3)];
      end
    end
    if (valid_o && !stall_i) begin
      if (lengths_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result at cycle %0d: magnitude %0d saturated %0b",
                   cycles, magnitude_o, saturated_o);
        end
      end else begin
        want = lengths_q.pop_front();
        if (magnitude_o !== want.magnitude || saturated_o !== want.saturated) begin
          report_mismatch(want, magnitude_o, saturated_o);
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    valid_i       = 1'b0;
    stall_i       = 1'b0;
    x_component_i = '0;
    y_component_i = '0;
    z_component_i = '0;

    // Directed corners: zero vector, unit and small roots, full-scale axes,
    // the most negative component alone and on all axes, and the two sides
    // of the saturation point.
    queue_vector(32'd0, 32'd0, 32'd0);
    queue_vector(32'd1, 32'd0, 32'd0);
    queue_vector(-32'sd1, -32'sd1, -32'sd1);
    queue_vector(32'd3, 32'd4, 32'd0);
    queue_vector(-32'sd2, 32'd3, -32'sd6);
    queue_vector(32'h7FFF_FFFF, 32'd0, 32'd0);
    queue_vector(32'd0, 32'h8000_0001, 32'd0);
    queue_vector(32'd0, 32'd0, 32'h8000_0000);
    queue_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_vector(32'd1518500249, 32'd1518500249, 32'd0);
    queue_vector(32'd1518500250, -32'sd1518500250, 32'd0);
    queue_vector(32'd1239850262, 32'd1239850262, 32'd1239850261);
    queue_vector(32'd1239850263, 32'd1239850263, 32'd1239850263);
    queue_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_vector(32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_FF00);
    queue_vector(32'd46340, 32'd46341, -32'sd46340);
    queue_vector(32'hFFFF_FFFE, 32'd2, 32'd0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      vectors_q.push_back(random_vector());
    end

    // Hold reset, then release it at a falling edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every vector to be taken, then for every result to drain,
    // then let the pipeline run on to catch any stray output.
    while (vectors_q.size() != 0 || valid_i) @(posedge clk_i);
    while (lengths_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== vec3_magnitude.f =====
hw/rtl/vm_pkg.sv
hw/rtl/vm_square.sv
hw/rtl/vm_sqrt.sv
hw/rtl/vm_outbuf.sv
hw/rtl/vec3_magnitude.sv
tb/testbench.sv
